// ===== rtl/core/bsra_pkg.sv =====
// Shared constants, types and helpers for the banker's safe resource allocator.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package bsra_pkg;

    // Sizing of the allocation problem
    localparam int CUSTOMERS      = 5;
    localparam int RESOURCE_KINDS = 4;
    localparam int COUNT_BITS     = 8;

    // Fixed field and register layout
    localparam int REG_W         = 32;
    localparam int CUST_BITS     = 3;
    localparam int AMT_BITS      = 8;
    localparam int AMOUNT_FIELDS = 4;
    localparam int CLAIM_REGS    = 5;
    localparam int NUM_REGS      = 1 + CLAIM_REGS;
    localparam int STATUS_BITS   = 3;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_RAW_W   = CUST_BITS + AMOUNT_FIELDS * AMT_BITS;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = $clog2(4 * NUM_REGS);
    localparam int RIDX_W     = APB_ADDR_W - 2;

    // Register indexes
    localparam int REG_INIT_AVAIL  = 0;
    localparam int REG_MAX_CLAIM_0 = 1;

    // Internal widths
    localparam int CIDX_W = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int SUM_W  = COUNT_BITS + $clog2(CUSTOMERS + 1);
    localparam int S_W    = ((SUM_W > AMT_BITS) ? SUM_W : AMT_BITS) + 2;

    // Result codes
    localparam logic [STATUS_BITS-1:0] STAT_GRANTED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_EXCEEDS    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_UNSAFE     = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_BAD_CUST   = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_RELEASED   = 3'd4;
    localparam logic [STATUS_BITS-1:0] STAT_OVER_ALLOC = 3'd5;

    // Sequencer command to every resource lane
    typedef struct packed {
        logic [CIDX_W-1:0] addr;      // customer row being read
        logic [CIDX_W-1:0] cust;      // customer of the current transaction
        logic              load_work; // seed the work vector for a safety scan
        logic              take;      // customer at addr finishes: add its trial allocation
        logic              grant;     // commit the request
        logic              retire;    // commit the release
    } lane_cmd_t;

    // What one lane found for its resource
    typedef struct packed {
        logic over_alloc; // amount above the allocation
        logic over_need;  // amount above the remaining claim
        logic over_avail; // amount above what is free
        logic fits;       // trial need of customer at addr within work
    } lane_flags_t;

    // Count of resource r from a packed register, zero beyond the register
    function automatic logic [COUNT_BITS-1:0] unpack_count(input logic [REG_W-1:0] word,
                                                           input int r);
        logic [REG_W-1:0] shifted;
        begin
            shifted = '0;
            if (r * COUNT_BITS < REG_W)
            begin
                shifted = word >> (r * COUNT_BITS);
            end
            return shifted[COUNT_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bankers_safe_resource_allocator_core.sv =====
// Top level of the banker's safe resource allocator: stream ports, APB port,
// sequencer and one lane per resource. Depends on bsra_pkg, bsra_regs,
// bsra_lane and bsra_ctrl.
`default_nettype none

// Each transaction asks for or gives back a vector of resource units for one
// customer and yields one status. A transaction is taken when the block is idle;
// in the next cycle the lanes check it against allocation, remaining claim and
// free units in parallel. Releases, bad customers and rejected requests finish
// in that check cycle. A request that passes runs the banker's safety scan, one
// customer per cycle with all resources compared at once across the lanes, for
// at most CUSTOMERS passes over CUSTOMERS customers. The result sits in an
// output register, so a new transaction is accepted while it waits. Write
// configuration only while no transaction is in flight.

module bankers_safe_resource_allocator_core
    import bsra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request/release stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // customer, amount_0..amount_3
    input  wire logic                  s_tuser,  // op
    // Status stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,  // status
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [REG_W-1:0]      pwdata,
    output logic      [REG_W-1:0]      prdata,
    output logic                       pready
);

    lane_cmd_t              cmd;
    lane_flags_t            lane_flags [RESOURCE_KINDS];
    logic [AMT_BITS-1:0]    in_amt     [RESOURCE_KINDS];
    logic [AMT_BITS-1:0]    lane_amt   [RESOURCE_KINDS];
    logic [COUNT_BITS-1:0]  lane_init  [RESOURCE_KINDS];
    logic [COUNT_BITS-1:0]  lane_max   [RESOURCE_KINDS];
    logic [REG_W-1:0]       init_word;
    logic [REG_W-1:0]       claim_word;
    logic [STATUS_BITS-1:0] status;

    bsra_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .claim_sel  (cmd.addr),
        .init_word  (init_word),
        .claim_word (claim_word)
    );

    bsra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_cust    (s_tdata[CUST_BITS-1:0]),
        .in_amt     (in_amt),
        .lane_flags (lane_flags),
        .cmd        (cmd),
        .lane_amt   (lane_amt),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status)
    );

    // One lane per resource kind
    for (genvar r = 0; r < RESOURCE_KINDS; r++)
    begin : g_lane
        if (r < AMOUNT_FIELDS)
        begin : g_amt
            assign in_amt[r] = s_tdata[CUST_BITS + r*AMT_BITS +: AMT_BITS];
        end
        else
        begin : g_no_amt
            assign in_amt[r] = '0;
        end

        assign lane_init[r] = unpack_count(init_word, r);
        assign lane_max[r]  = unpack_count(claim_word, r);

        bsra_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .amount     (lane_amt[r]),
            .init_count (lane_init[r]),
            .max_count  (lane_max[r]),
            .flags      (lane_flags[r])
        );
    end

    assign m_tdata = OUT_DATA_W'(status);

    // The block is busy in the cycle after it takes a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction was in progress");

    // Only defined status codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status <= STAT_OVER_ALLOC))
        else $error("undefined status code on output");

    // A scan never starts without a fresh transaction check before it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_work |-> !$past(s_tready) || $past(s_tvalid))
        else $error("safety scan started without a checked transaction");

endmodule

`default_nettype wire

// ===== rtl/core/bsra_regs.sv =====
// Configuration register file with an APB-style port.
// Depends on bsra_pkg for the register map and the claim lookup width.
`default_nettype none

module bsra_regs
    import bsra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [REG_W-1:0]      pwdata,
    output logic      [REG_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic [CIDX_W-1:0]     claim_sel,
    output logic      [REG_W-1:0]      init_word,
    output logic      [REG_W-1:0]      claim_word
);

    logic [REG_W-1:0]  init_reg;
    logic [REG_W-1:0]  claim_reg [CLAIM_REGS];
    logic [RIDX_W-1:0] reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Store register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            for (int i = 0; i < CLAIM_REGS; i++)
            begin
                claim_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == RIDX_W'(REG_INIT_AVAIL))
            begin
                init_reg <= pwdata;
            end
            for (int i = 0; i < CLAIM_REGS; i++)
            begin
                if (reg_idx == RIDX_W'(REG_MAX_CLAIM_0 + i))
                begin
                    claim_reg[i] <= pwdata;
                end
            end
        end
    end

    // Return register contents on reads
    always_comb
    begin
        prdata = '0;
        if (reg_idx == RIDX_W'(REG_INIT_AVAIL))
        begin
            prdata = init_reg;
        end
        for (int i = 0; i < CLAIM_REGS; i++)
        begin
            if (reg_idx == RIDX_W'(REG_MAX_CLAIM_0 + i))
            begin
                prdata = claim_reg[i];
            end
        end
    end

    // Select the claim of the customer row under test; no register means zero
    always_comb
    begin
        claim_word = '0;
        for (int i = 0; i < CLAIM_REGS; i++)
        begin
            if (i < CUSTOMERS && claim_sel == CIDX_W'(i))
            begin
                claim_word = claim_reg[i];
            end
        end
    end

    assign init_word = init_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bsra_lane.sv =====
// One resource lane: holds the allocation column and column sum of one resource,
// compares against need and available, and keeps the safety-scan work count.
// Depends on bsra_pkg.
`default_nettype none

module bsra_lane
    import bsra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lane_cmd_t             cmd,
    input  wire logic [AMT_BITS-1:0]   amount,
    input  wire logic [COUNT_BITS-1:0] init_count,
    input  wire logic [COUNT_BITS-1:0] max_count,
    output lane_flags_t                flags
);

    logic        [COUNT_BITS-1:0] alloc_reg [CUSTOMERS];
    logic        [SUM_W-1:0]      colsum_reg;
    logic signed [S_W-1:0]        work_reg;

    logic        [COUNT_BITS-1:0] alloc_rd;
    logic signed [S_W-1:0]        amt_s;
    logic signed [S_W-1:0]        alloc_s;
    logic signed [S_W-1:0]        max_s;
    logic signed [S_W-1:0]        avail_s;
    logic signed [S_W-1:0]        need_s;
    logic signed [S_W-1:0]        trial_s;
    logic signed [S_W-1:0]        need_trial_s;

    // Read the allocation of the addressed customer
    always_comb
    begin
        alloc_rd = '0;
        for (int i = 0; i < CUSTOMERS; i++)
        begin
            if (cmd.addr == CIDX_W'(i))
            begin
                alloc_rd = alloc_reg[i];
            end
        end
    end

    // Need, available and trial need for this resource
    assign amt_s        = S_W'(amount);
    assign alloc_s      = S_W'(alloc_rd);
    assign max_s        = S_W'(max_count);
    assign avail_s      = S_W'(init_count) - S_W'(colsum_reg);
    assign need_s       = max_s - alloc_s;
    assign trial_s      = alloc_s + ((cmd.addr == cmd.cust) ? amt_s : '0);
    assign need_trial_s = max_s - trial_s;

    assign flags.over_alloc = amt_s > alloc_s;
    assign flags.over_need  = amt_s > need_s;
    assign flags.over_avail = amt_s > avail_s;
    assign flags.fits       = need_trial_s <= work_reg;

    // Advance the work count during a scan; commit grants and releases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CUSTOMERS; i++)
            begin
                alloc_reg[i] <= '0;
            end
            colsum_reg <= '0;
            work_reg   <= '0;
        end
        else
        begin
            if (cmd.load_work)
            begin
                work_reg <= avail_s - amt_s;
            end
            else if (cmd.take)
            begin
                work_reg <= work_reg + trial_s;
            end

            if (cmd.grant)
            begin
                for (int i = 0; i < CUSTOMERS; i++)
                begin
                    if (cmd.cust == CIDX_W'(i))
                    begin
                        alloc_reg[i] <= alloc_reg[i] + COUNT_BITS'(amount);
                    end
                end
                colsum_reg <= colsum_reg + SUM_W'(amount);
            end
            else if (cmd.retire)
            begin
                for (int i = 0; i < CUSTOMERS; i++)
                begin
                    if (cmd.cust == CIDX_W'(i))
                    begin
                        alloc_reg[i] <= alloc_reg[i] - COUNT_BITS'(amount);
                    end
                end
                colsum_reg <= colsum_reg - SUM_W'(amount);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bsra_ctrl.sv =====
// Sequencer: captures a transaction, merges the lane flags, runs the safety scan
// one customer per cycle and holds the result register. Depends on bsra_pkg.
`default_nettype none

module bsra_ctrl
    import bsra_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   in_op,
    input  wire logic [CUST_BITS-1:0]   in_cust,
    input  wire logic [AMT_BITS-1:0]    in_amt [RESOURCE_KINDS],
    input  wire lane_flags_t            lane_flags [RESOURCE_KINDS],
    output lane_cmd_t                   cmd,
    output logic      [AMT_BITS-1:0]    lane_amt [RESOURCE_KINDS],
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [STATUS_BITS-1:0] out_status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(CUSTOMERS - 1);

    logic [1:0]             state_reg, state_next;
    logic                   op_reg;
    logic [CUST_BITS-1:0]   cust_reg;
    logic [AMT_BITS-1:0]    amt_reg [RESOURCE_KINDS];
    logic [CIDX_W-1:0]      idx_reg, idx_next;
    logic [CUSTOMERS-1:0]   done_reg, done_next;
    logic                   progress_reg, progress_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [STATUS_BITS-1:0] hold_status_reg, hold_status_next;

    logic                   any_over_alloc;
    logic                   any_over;
    logic                   all_fits;
    logic                   cust_ok;
    logic                   idx_done;
    logic                   take;
    logic                   progress_now;
    logic                   fin;
    logic [STATUS_BITS-1:0] fin_status;
    logic                   out_free;
    logic                   out_load;
    logic [STATUS_BITS-1:0] out_load_status;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign cust_ok    = 32'(cust_reg) < CUSTOMERS;
    assign out_free   = !out_valid_reg || out_ready;

    // Merge what the lanes found
    always_comb
    begin
        any_over_alloc = 1'b0;
        any_over       = 1'b0;
        all_fits       = 1'b1;
        for (int r = 0; r < RESOURCE_KINDS; r++)
        begin
            any_over_alloc = any_over_alloc | lane_flags[r].over_alloc;
            any_over       = any_over | lane_flags[r].over_need | lane_flags[r].over_avail;
            all_fits       = all_fits & lane_flags[r].fits;
        end
    end

    // Done flag of the customer under scan
    always_comb
    begin
        idx_done = 1'b0;
        for (int i = 0; i < CUSTOMERS; i++)
        begin
            if (idx_reg == CIDX_W'(i))
            begin
                idx_done = done_reg[i];
            end
        end
    end

    assign take         = (state_reg == ST_SCAN) && !idx_done && all_fits;
    assign progress_now = progress_reg || take;

    always_comb
    begin
        for (int r = 0; r < RESOURCE_KINDS; r++)
        begin
            lane_amt[r] = amt_reg[r];
        end
    end

    // Sequence one transaction
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        done_next        = done_reg;
        progress_next    = progress_reg;
        hold_status_next = hold_status_reg;
        fin              = 1'b0;
        fin_status       = STAT_GRANTED;
        out_load         = 1'b0;
        out_load_status  = STAT_GRANTED;

        cmd.cust      = CIDX_W'(cust_reg);
        cmd.addr      = (state_reg == ST_SCAN) ? idx_reg : CIDX_W'(cust_reg);
        cmd.load_work = 1'b0;
        cmd.take      = take;
        cmd.grant     = 1'b0;
        cmd.retire    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!cust_ok)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_BAD_CUST;
                end
                else if (op_reg)
                begin
                    fin = 1'b1;
                    if (any_over_alloc)
                    begin
                        fin_status = STAT_OVER_ALLOC;
                    end
                    else
                    begin
                        cmd.retire = 1'b1;
                        fin_status = STAT_RELEASED;
                    end
                end
                else if (any_over)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_EXCEEDS;
                end
                else
                begin
                    cmd.load_work = 1'b1;
                    done_next     = '0;
                    idx_next      = '0;
                    progress_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                for (int i = 0; i < CUSTOMERS; i++)
                begin
                    if (idx_reg == CIDX_W'(i) && take)
                    begin
                        done_next[i] = 1'b1;
                    end
                end
                if (&done_next)
                begin
                    cmd.grant  = 1'b1;
                    fin        = 1'b1;
                    fin_status = STAT_GRANTED;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (!progress_now)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_UNSAFE;
                    end
                    else
                    begin
                        idx_next      = '0;
                        progress_next = 1'b0;
                    end
                end
                else
                begin
                    idx_next      = idx_reg + 1'b1;
                    progress_next = progress_now;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_load_status = hold_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it while that is busy
        if (fin)
        begin
            if (out_free)
            begin
                out_load        = 1'b1;
                out_load_status = fin_status;
                state_next      = ST_IDLE;
            end
            else
            begin
                hold_status_next = fin_status;
                state_next       = ST_HOLD;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = out_load_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            done_reg        <= '0;
            progress_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STAT_GRANTED;
            hold_status_reg <= STAT_GRANTED;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            done_reg        <= done_next;
            progress_reg    <= progress_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            hold_status_reg <= hold_status_next;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= in_op;
            cust_reg <= in_cust;
            for (int r = 0; r < RESOURCE_KINDS; r++)
            begin
                amt_reg[r] <= in_amt[r];
            end
        end
    end

endmodule

`default_nettype wire
